[src/asd_pkg.sv]
// Shared types and constants for the single data transfer block.
package asd_pkg;

  // Register file geometry
  localparam int NUM_REGS = 16;
  localparam int REG_AW   = 4;

  // Shift type codes from the offset specifier
  localparam logic [1:0] SH_LSL = 2'd0;
  localparam logic [1:0] SH_LSR = 2'd1;
  localparam logic [1:0] SH_ASR = 2'd2;
  localparam logic [1:0] SH_ROR = 2'd3;

  // Sequencer states
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD1  = 7'b0000010,
    S_RD2  = 7'b0000100,
    S_ADR  = 7'b0001000,
    S_MEM  = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_SPR  = 7'b1000000
  } state_t;

  // Register file write port
  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] addr;
    logic [31:0]       data;
  } rf_wr_t;

  // Data memory access request
  typedef struct packed {
    logic       we;
    logic       re;
    logic [7:0] wdata;
  } mem_req_t;

endpackage

[src/asd_regfile.sv]
// Register file: 16 x 32 synchronous memory, two read ports, one write port, valid bits.
module asd_regfile (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [asd_pkg::REG_AW-1:0] rd_addr_a,
  input  logic [asd_pkg::REG_AW-1:0] rd_addr_b,
  output logic [31:0]               rd_data_a,
  output logic [31:0]               rd_data_b,
  input  asd_pkg::rf_wr_t           wr
);
  import asd_pkg::*;

  logic [31:0]         mem [NUM_REGS];
  logic [NUM_REGS-1:0] valid_r;
  logic [31:0]         rdata_a_r;
  logic [31:0]         rdata_b_r;
  logic                va_r;
  logic                vb_r;

  // Storage array and registered reads
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_a_r <= mem[rd_addr_a];
    rdata_b_r <= mem[rd_addr_b];
  end

  // Valid bits: an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      va_r    <= 1'b0;
      vb_r    <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
      end
      va_r <= valid_r[rd_addr_a];
      vb_r <= valid_r[rd_addr_b];
    end
  end

  assign rd_data_a = va_r ? rdata_a_r : '0;
  assign rd_data_b = vb_r ? rdata_b_r : '0;

endmodule

[src/asd_datamem.sv]
// Byte-wide data memory with a clearing sweep after reset.
module asd_datamem #(
  parameter int MEM_BYTES = 65536,
  parameter int AW        = $clog2(MEM_BYTES)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [AW-1:0]     addr,
  input  asd_pkg::mem_req_t req,
  output logic [7:0]        rdata,
  output logic              busy
);
  import asd_pkg::*;

  logic [7:0]    mem [MEM_BYTES];
  logic [7:0]    rdata_r;
  logic          clr_busy_r;
  logic [AW-1:0] clr_idx_r;

  // Clearing sweep, one byte per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_idx_r == AW'(MEM_BYTES - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_idx_r <= clr_idx_r + AW'(1);
    end
  end

  // Single write port, registered read
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_idx_r] <= '0;
    end else if (req.we) begin
      mem[addr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;
  assign busy  = clr_busy_r;

endmodule

[src/asd_shifter.sv]
// Barrel shifter for the register offset: LSL, LSR, ASR, ROR with ARM amount rules.
module asd_shifter (
  input  logic [31:0] value,
  input  logic [7:0]  amount,
  input  logic [1:0]  sh_type,
  output logic [31:0] result
);
  import asd_pkg::*;

  logic        big;
  logic [4:0]  sa;
  logic [63:0] rot;

  assign big = |amount[7:5];
  assign sa  = amount[4:0];
  assign rot = {value, value} >> sa;

  always_comb begin
    if (amount == 8'd0) begin
      result = value;
    end else begin
      case (sh_type)
        SH_LSL:  result = big ? 32'd0 : (value << sa);
        SH_LSR:  result = big ? 32'd0 : (value >> sa);
        SH_ASR:  result = big ? {32{value[31]}} : 32'($signed(value) >>> sa);
        SH_ROR:  result = rot[31:0];
        default: result = value;
      endcase
    end
  end

endmodule

[src/arm_single_data_transfer.sv]
// Single data transfer (word LDR/STR) engine, one instruction at a time.
// Each accepted beat steps through two register file read rounds (RD1, RD2), a spare state,
// the address add (ADR), the byte accesses for four bytes (MEM) and the hand-off (FIN);
// in_tready returns high only once the result has been loaded into the output register.
// Reset: synchronous active-low; clears the control registers and the valid bits, then sweeps
// the data memory to zero with in_tready low.
module arm_single_data_transfer #(
  parameter int MEM_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [0] reg_offset, [1] pre_index, [2] add_offset, [3] is_load,
  // [7:4] base_reg, [11:8] data_reg, [23:12] offset_field
  input  logic [23:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] eff_address, [63:32] load_value, [64] out_of_range, [71:65] zero
  output logic [71:0] out_tdata
);
  import asd_pkg::*;

  localparam int MAW = $clog2(MEM_BYTES);

  state_t state_r, state_nxt;
  logic [2:0]  cnt_r, cnt_nxt;

  logic        regofs_r, pre_r, add_r, load_r;
  logic [3:0]  rn_r, rd_r;
  logic [11:0] field_r;
  logic [31:0] rn_val_r, rm_val_r, rd_val_r, offset_r;
  logic [31:0] addr_r, st_word_r, ld_word_r;
  logic        oor_r;
  logic        out_valid_r;
  logic [71:0] out_data_r;

  logic [REG_AW-1:0] rf_addr_a, rf_addr_b;
  logic [31:0]       rf_data_a, rf_data_b;
  rf_wr_t            rf_wr;
  mem_req_t          mem_req;
  logic [MAW-1:0]    mem_addr;
  logic [7:0]        mem_rdata;
  logic              mem_busy;
  logic [7:0]        sh_amt;
  logic [31:0]       sh_res;
  logic [31:0]       sum;
  logic              oor;
  logic              in_fire, out_load;
  logic [31:0]       result_val;

  asd_regfile u_rf (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_addr_a (rf_addr_a),
    .rd_addr_b (rf_addr_b),
    .rd_data_a (rf_data_a),
    .rd_data_b (rf_data_b),
    .wr        (rf_wr)
  );

  asd_datamem #(.MEM_BYTES(MEM_BYTES), .AW(MAW)) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .addr  (mem_addr),
    .req   (mem_req),
    .rdata (mem_rdata),
    .busy  (mem_busy)
  );

  asd_shifter u_sh (
    .value   (rm_val_r),
    .amount  (sh_amt),
    .sh_type (field_r[6:5]),
    .result  (sh_res)
  );

  assign in_tready = (state_r == S_IDLE) && !mem_busy;
  assign in_fire   = in_tvalid && in_tready;
  assign out_load  = (state_r == S_FIN) && (!out_valid_r || out_tready);

  // Register file read addresses: Rn/Rm on accept, then Rs/Rd
  always_comb begin
    if (state_r == S_IDLE) begin
      rf_addr_a = in_tdata[7:4];
      rf_addr_b = in_tdata[15:12];
    end else begin
      rf_addr_a = field_r[11:8];
      rf_addr_b = rd_r;
    end
  end

  // Shift amount: Rs low byte or the 5-bit constant
  assign sh_amt = field_r[4] ? rf_data_a[7:0] : {3'b000, field_r[11:7]};

  // Address arithmetic
  assign sum = add_r ? (rn_val_r + offset_r) : (rn_val_r - offset_r);
  always_comb begin
    logic [31:0] a;
    a   = pre_r ? sum : rn_val_r;
    oor = ({1'b0, a} + 33'd4) > 33'(MEM_BYTES);
  end

  assign result_val = load_r ? (oor_r ? addr_r : ld_word_r) : 32'd0;

  // Register file write: base writeback, then load destination
  always_comb begin
    rf_wr = '0;
    if (state_r == S_ADR && !pre_r) begin
      rf_wr.en   = 1'b1;
      rf_wr.addr = rn_r;
      rf_wr.data = sum;
    end else if (out_load && load_r) begin
      rf_wr.en   = 1'b1;
      rf_wr.addr = rd_r;
      rf_wr.data = result_val;
    end
  end

  // Byte accesses, one per cycle
  assign mem_addr      = addr_r[MAW-1:0] + MAW'(cnt_r[1:0]);
  assign mem_req.we    = (state_r == S_MEM) && !cnt_r[2] && !load_r && !oor_r;
  assign mem_req.re    = (state_r == S_MEM) && !cnt_r[2] && load_r && !oor_r;
  assign mem_req.wdata = st_word_r[7:0];

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: if (in_fire) begin
        state_nxt = S_RD1;
      end
      S_RD1:  state_nxt = S_RD2;
      S_RD2:  state_nxt = S_SPR;
      S_SPR:  state_nxt = S_ADR;
      S_ADR: begin
        state_nxt = S_MEM;
        cnt_nxt   = 3'd0;
      end
      S_MEM: begin
        if (cnt_r[2]) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      S_FIN: if (out_load) begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      regofs_r <= in_tdata[0];
      pre_r    <= in_tdata[1];
      add_r    <= in_tdata[2];
      load_r   <= in_tdata[3];
      rn_r     <= in_tdata[7:4];
      rd_r     <= in_tdata[11:8];
      field_r  <= in_tdata[23:12];
    end
    if (state_r == S_RD1) begin
      rn_val_r <= rf_data_a;
      rm_val_r <= rf_data_b;
    end
    if (state_r == S_RD2) begin
      rd_val_r <= rf_data_b;
      offset_r <= regofs_r ? sh_res : {20'd0, field_r};
    end
    if (state_r == S_ADR) begin
      addr_r    <= pre_r ? sum : rn_val_r;
      oor_r     <= oor;
      // store of the base register after post-index sees the updated base
      st_word_r <= (!pre_r && rd_r == rn_r) ? sum : rd_val_r;
    end
    if (state_r == S_MEM) begin
      if (mem_req.we) begin
        st_word_r <= {8'd0, st_word_r[31:8]};
      end
      if (cnt_r != 3'd0) begin
        ld_word_r <= {mem_rdata, ld_word_r[31:8]};
      end
    end
    if (out_load) begin
      out_data_r <= {7'd0, oor_r, result_val, addr_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[src/asd_checker.sv]
// Port-level checks for the single data transfer block, bound to the top level.
module asd_checker #(
  parameter int MEM_BYTES = 65536
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);

  // Memory sweep holds off input right after reset
  a_reset_holds: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("in_tready high right after reset");

  // One instruction at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second beat accepted while busy");

  // Result beat holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // Range flag matches the reported address
  a_oor_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[64] == (({1'b0, out_tdata[31:0]} + 33'd4) > 33'(MEM_BYTES)))
    else $error("out_of_range inconsistent with address");

  // Out of range: load returns the address, store returns zero
  a_oor_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[64] |->
      (out_tdata[63:32] == out_tdata[31:0]) || (out_tdata[63:32] == 32'd0))
    else $error("bad load value for out-of-range access");

endmodule

bind arm_single_data_transfer asd_checker #(.MEM_BYTES(MEM_BYTES)) u_asd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[tb/transfer_sb_pkg.sv]
`timescale 1ns / 1ps
// Beat layouts and the scoreboard that predicts word LDR/STR results.
package transfer_sb_pkg;
  import asd_pkg::*;

  // Input beat, fields listed from the top bit down
  typedef struct packed {
    logic [11:0] offset_field;
    logic [3:0]  data_reg;
    logic [3:0]  base_reg;
    logic        is_load;
    logic        add_offset;
    logic        pre_index;
    logic        reg_offset;
  } xfer_t;

  // Result beat, fields listed from the top bit down
  typedef struct packed {
    logic [6:0]  pad;
    logic        out_of_range;
    logic [31:0] load_value;
    logic [31:0] eff_address;
  } xfer_res_t;

  class transfer_scoreboard;
    bit [31:0]   regs [NUM_REGS];
    bit [7:0]    mem [];
    int unsigned mem_bytes;
    xfer_res_t   expected_results [$];
    int          errors;
    int          checked;
    int          loads;
    int          beyond;

    function new(int unsigned bytes);
      mem_bytes = bytes;
      mem = new[bytes];
    endfunction

    // Barrel shifter for register offsets; amount is the full 8 bits
    function bit [31:0] shift_offset(bit [31:0] v, bit [7:0] amt, logic [1:0] kind);
      bit [4:0] rot;
      rot = amt[4:0];
      if (amt == 8'd0) return v;
      case (kind)
        SH_LSL: begin
          if (amt >= 8'd32) return 32'd0;
          return v << amt;
        end
        SH_LSR: begin
          if (amt >= 8'd32) return 32'd0;
          return v >> amt;
        end
        SH_ASR: begin
          if (amt >= 8'd32) return {32{v[31]}};
          return $signed(v) >>> amt;
        end
        default: begin
          if (rot == 5'd0) return v;
          return (v >> rot) | (v << (6'd32 - rot));
        end
      endcase
    endfunction

    // Apply one accepted instruction to the register/memory copy and queue its result
    function void note_transfer(xfer_t it);
      bit [31:0] offset;
      bit [31:0] base_val;
      bit [31:0] sum;
      bit [31:0] addr;
      bit [31:0] value;
      bit [31:0] word;
      bit [7:0]  amt;
      bit        oor;
      xfer_res_t res;
      offset = {20'd0, it.offset_field};
      if (it.reg_offset) begin
        if (it.offset_field[4]) amt = regs[it.offset_field[11:8]][7:0];
        else amt = {3'd0, it.offset_field[11:7]};
        offset = shift_offset(regs[it.offset_field[3:0]], amt, it.offset_field[6:5]);
      end
      base_val = regs[it.base_reg];
      sum = it.add_offset ? base_val + offset : base_val - offset;
      // post-index: base is the address, writeback before the data access
      if (it.pre_index) begin
        addr = sum;
      end else begin
        addr = base_val;
        regs[it.base_reg] = sum;
      end
      oor = ({32'd0, addr} + 64'd4) > 64'(mem_bytes);
      value = '0;
      if (it.is_load) begin
        value = oor ? addr : {mem[addr + 3], mem[addr + 2], mem[addr + 1], mem[addr]};
        regs[it.data_reg] = value;
        loads++;
      end else if (!oor) begin
        word = regs[it.data_reg];
        for (int i = 0; i < 4; i++) mem[addr + i] = word[8*i +: 8];
      end
      if (oor) beyond++;
      res.pad = '0;
      res.out_of_range = oor;
      res.load_value = value;
      res.eff_address = addr;
      expected_results.push_back(res);
    endfunction

    // Compare one result beat against the oldest prediction
    function void check_result(xfer_res_t got);
      xfer_res_t want;
      if (expected_results.size() == 0) begin
        $error("result beat with no transfer pending: %h", got);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      checked++;
      if (got.eff_address !== want.eff_address) begin
        $error("eff_address: expected %h, actual %h", want.eff_address, got.eff_address);
        errors++;
      end
      if (got.load_value !== want.load_value) begin
        $error("load_value: expected %h, actual %h", want.load_value, got.load_value);
        errors++;
      end
      if (got.out_of_range !== want.out_of_range) begin
        $error("out_of_range: expected %b, actual %b", want.out_of_range, got.out_of_range);
        errors++;
      end
      if (got.pad !== want.pad) begin
        $error("reserved bits: expected %h, actual %h", want.pad, got.pad);
        errors++;
      end
    endfunction
  endclass

endpackage

[tb/testbench.sv]
`timescale 1ns / 1ps
// Top-level testbench: streams LDR/STR beats into the transfer engine and checks each result.
module testbench;
  import asd_pkg::*;
  import transfer_sb_pkg::*;

  localparam int     MEM_BYTES    = 65536;
  localparam int     RANDOM_ITEMS = 950;
  localparam int     PHASES       = 4;
  localparam int     DRAIN_CYCLES = 20;
  localparam longint CYCLE_LIMIT  = 1_000_000;

  // Instruction bit meanings
  localparam bit OFS_IMM    = 1'b0;
  localparam bit OFS_REG    = 1'b1;
  localparam bit IDX_POST   = 1'b0;
  localparam bit IDX_PRE    = 1'b1;
  localparam bit OP_SUB     = 1'b0;
  localparam bit OP_ADD     = 1'b1;
  localparam bit XFER_STORE = 1'b0;
  localparam bit XFER_LOAD  = 1'b1;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;

  int unsigned        in_idle_pct   = 0;
  int unsigned        out_stall_pct = 0;
  int                 sent          = 0;
  longint             cycles        = 0;
  transfer_scoreboard sb;

  arm_single_data_transfer #(
    .MEM_BYTES(MEM_BYTES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: check accepted beats, stall at random
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    out_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  function automatic xfer_t xfer(bit ro, bit pre, bit add, bit ld, bit [3:0] rn, bit [3:0] rd,
                                 bit [11:0] fld);
    return {fld, rd, rn, ld, add, pre, ro};
  endfunction

  // Shift specifier with a constant amount
  function automatic bit [11:0] by_const(bit [3:0] rm, logic [1:0] kind, bit [4:0] amt);
    return {amt, kind, 1'b0, rm};
  endfunction

  // Shift specifier with the amount from Rs; bit 7 is don't-care
  function automatic bit [11:0] by_reg(bit [3:0] rm, logic [1:0] kind, bit [3:0] rs);
    return {rs, 1'($urandom_range(1)), kind, 1'b1, rm};
  endfunction

  // One beat on the input channel, with random idle cycles ahead of it
  task automatic send_transfer(xfer_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= it;
    do @(posedge clk); while (!in_tready);
    sb.note_transfer(it);
    sent++;
  endtask

  // r = r - (r LSL #0) via post-index writeback
  task automatic clear_reg(bit [3:0] r);
    send_transfer(xfer(OFS_REG, IDX_POST, OP_SUB, XFER_STORE, r, 4'($urandom),
                       by_const(r, SH_LSL, 5'd0)));
  endtask

  task automatic step_reg(bit [3:0] r, bit [11:0] imm, bit add);
    send_transfer(xfer(OFS_IMM, IDX_POST, add, XFER_STORE, r, 4'($urandom), imm));
  endtask

  // Load r with an address below 64K: hi*17, then fix up by (lo - hi)
  task automatic point_reg(bit [3:0] r, bit [31:0] addr);
    int diff;
    clear_reg(r);
    step_reg(r, addr[15:4], OP_ADD);
    send_transfer(xfer(OFS_REG, IDX_POST, OP_ADD, XFER_STORE, r, 4'($urandom),
                       by_const(r, SH_LSL, 5'd4)));
    diff = int'(addr) - int'(sb.regs[r]);
    step_reg(r, 12'(diff < 0 ? -diff : diff), diff >= 0);
  endtask

  // Pre-index load with a random shifted-register offset; mostly lands beyond
  // memory, so rd picks up a freshly mixed address value
  task automatic mix_reg(bit [3:0] rd);
    send_transfer(xfer(OFS_REG, IDX_PRE, 1'($urandom_range(1)), XFER_LOAD,
                       4'($urandom), rd, 12'($urandom)));
  endtask

  // Point a base at memory, then a run of stores and loads around it
  task automatic memory_block();
    bit [3:0]  b;
    bit [3:0]  rd;
    bit [31:0] addr;
    int        off;
    b = 4'($urandom_range(15));
    if ($urandom_range(7) == 0) addr = 32'(MEM_BYTES - 8) + $urandom_range(7);
    else addr = $urandom_range(MEM_BYTES - 1);
    point_reg(b, addr);
    repeat ($urandom_range(3, 8)) begin
      rd = 4'($urandom_range(15));
      if (rd == b && $urandom_range(3) != 0) rd = b + 4'd1;
      off = int'($urandom_range(2)) * 4;
      if ($urandom_range(4) == 0) off += int'($urandom_range(1, 3));
      if ($urandom_range(3) == 0) mix_reg(rd);
      else send_transfer(xfer(OFS_IMM, 1'($urandom_range(1)), 1'($urandom_range(1)),
                              1'($urandom_range(1)), b, rd, 12'(off)));
    end
  endtask

  task automatic random_block();
    int pick;
    pick = int'($urandom_range(99));
    if (pick < 55) memory_block();
    else if (pick < 80) repeat ($urandom_range(1, 3)) mix_reg(4'($urandom));
    else send_transfer(xfer_t'(24'($urandom)));
  endtask

  // Corner cases, starting from the all-zero register file
  task automatic directed_checks();
    // largest immediate, post-index: r1 = 4095
    send_transfer(xfer(OFS_IMM, IDX_POST, OP_ADD, XFER_STORE, 1, 0, 12'hFFF));
    // subtract below zero wraps: r2 = all ones
    send_transfer(xfer(OFS_IMM, IDX_POST, OP_SUB, XFER_LOAD, 2, 3, 12'd1));
    // load beyond memory returns the address itself
    send_transfer(xfer(OFS_IMM, IDX_PRE, OP_ADD, XFER_LOAD, 2, 4, 12'd0));
    send_transfer(xfer(OFS_REG, IDX_PRE, OP_ADD, XFER_LOAD, 0, 5, by_const(4, SH_LSL, 5'd31)));
    // register amount 255: ASR fills with sign, LSR/LSL give zero, ROR acts as 31
    send_transfer(xfer(OFS_REG, IDX_PRE, OP_ADD, XFER_LOAD, 0, 6, by_reg(5, SH_ASR, 1)));
    send_transfer(xfer(OFS_REG, IDX_PRE, OP_ADD, XFER_STORE, 1, 4, by_reg(4, SH_LSR, 1)));
    send_transfer(xfer(OFS_REG, IDX_PRE, OP_SUB, XFER_LOAD, 1, 7, by_reg(4, SH_LSL, 1)));
    send_transfer(xfer(OFS_REG, IDX_PRE, OP_ADD, XFER_LOAD, 1, 8, by_reg(5, SH_ROR, 1)));
    // constant amount zero leaves Rm untouched for ASR and ROR
    send_transfer(xfer(OFS_REG, IDX_PRE, OP_ADD, XFER_LOAD, 0, 9, by_const(5, SH_ASR, 5'd0)));
    send_transfer(xfer(OFS_REG, IDX_PRE, OP_ADD, XFER_LOAD, 0, 10, by_const(1, SH_ROR, 5'd0)));
    // register amount of exactly 32 (r11 = 32)
    send_transfer(xfer(OFS_IMM, IDX_POST, OP_ADD, XFER_STORE, 11, 0, 12'd32));
    send_transfer(xfer(OFS_REG, IDX_PRE, OP_ADD, XFER_LOAD, 1, 12, by_reg(4, SH_LSR, 11)));
    send_transfer(xfer(OFS_REG, IDX_PRE, OP_ADD, XFER_LOAD, 0, 12, by_reg(4, SH_LSL, 11)));
    send_transfer(xfer(OFS_REG, IDX_PRE, OP_ADD, XFER_LOAD, 0, 12, by_reg(5, SH_ASR, 11)));
    send_transfer(xfer(OFS_REG, IDX_PRE, OP_ADD, XFER_LOAD, 12, 13, by_reg(5, SH_ROR, 11)));
    // zero register amount; store beyond memory is dropped
    send_transfer(xfer(OFS_REG, IDX_PRE, OP_ADD, XFER_STORE, 0, 6, by_reg(4, SH_LSR, 0)));
    // walk r14 to the last whole word of memory
    send_transfer(xfer(OFS_REG, IDX_POST, OP_ADD, XFER_STORE, 14, 7, by_const(1, SH_LSL, 5'd4)));
    send_transfer(xfer(OFS_IMM, IDX_POST, OP_ADD, XFER_STORE, 14, 4, 12'd12));
    send_transfer(xfer(OFS_IMM, IDX_PRE, OP_ADD, XFER_STORE, 14, 5, 12'd0));
    send_transfer(xfer(OFS_IMM, IDX_PRE, OP_ADD, XFER_LOAD, 14, 9, 12'd1));
    send_transfer(xfer(OFS_IMM, IDX_PRE, OP_ADD, XFER_LOAD, 14, 10, 12'd0));
    // base == destination: writeback first, then the load overwrites it
    send_transfer(xfer(OFS_IMM, IDX_POST, OP_ADD, XFER_LOAD, 14, 14, 12'd4));
    // base == source: the updated base is stored; read back into r15
    send_transfer(xfer(OFS_IMM, IDX_POST, OP_ADD, XFER_STORE, 11, 11, 12'd8));
    send_transfer(xfer(OFS_IMM, IDX_PRE, OP_ADD, XFER_LOAD, 0, 15, 12'd32));
  endtask

  // Main sequence
  initial begin
    int random_start;
    sb = new(MEM_BYTES);
    random_start = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          in_idle_pct = 0;
          out_stall_pct = 0;
        end
        1: begin
          in_idle_pct = 76;
          out_stall_pct = 0;
        end
        2: begin
          in_idle_pct = 0;
          out_stall_pct = 76;
        end
        default: begin
          in_idle_pct = 37;
          out_stall_pct = 37;
        end
      endcase
      if (ph == 0) begin
        directed_checks();
        random_start = sent;
      end
      while (sent < random_start + RANDOM_ITEMS * (ph + 1) / PHASES) random_block();
    end
    in_tvalid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d transfers: %0d loads, %0d beyond the end of memory,",
             sb.checked, sb.loads, sb.beyond);
    $display("over four pacing phases (free flow, sparse input, stalled output, both).");
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
src/asd_pkg.sv
src/asd_regfile.sv
src/asd_datamem.sv
src/asd_shifter.sv
src/arm_single_data_transfer.sv
src/asd_checker.sv
tb/transfer_sb_pkg.sv
tb/testbench.sv
